@@ rtl/mbad_pkg.sv @@
// Shared types and constants of the multichannel block average decimator.
`timescale 1ns / 1ps
`default_nettype none
package mbad_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 16;
    localparam int CHAN_IDX_W = 6;
    localparam int SUM_W      = 32;
    localparam int SCALE_W    = 32;
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int NCH_W      = 7;
    localparam int FLEN_W     = 13;

    // Register map: index is paddr[3:2]
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [1:0] REG_FRAME_LENGTH = 2'd1;
    localparam logic [1:0] REG_OUTPUT_SCALE = 2'd2;

    // Register reset values
    localparam logic [NCH_W-1:0]          NUM_CHANNELS_RST = 7'd1;
    localparam logic [FLEN_W-1:0]         FRAME_LENGTH_RST = 13'd2;
    localparam logic signed [SCALE_W-1:0] OUTPUT_SCALE_RST = 32'sd32768;

    // Saturation limits of the Q1.15 result
    localparam logic signed [PROD_W-17:0] SAT_HI = 48'sd32767;
    localparam logic signed [PROD_W-17:0] SAT_LO = -48'sd32768;
    localparam logic signed [AVG_W-1:0]   AVG_MAX = 16'sh7FFF;
    localparam logic signed [AVG_W-1:0]   AVG_MIN = 16'sh8000;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [NCH_W-1:0]          num_channels;
        logic [FLEN_W-1:0]         frame_length;
        logic signed [SCALE_W-1:0] output_scale;
    } t_cfg;

    // Finished frame sum handed to the scaling stage
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CHAN_IDX_W-1:0]   channel_index;
        logic                    frame_last;
    } t_sc_req;

endpackage
`default_nettype wire

@@ rtl/mbad_in_if.sv @@
// Valid/ready channel carrying one interleaved input sample.
`timescale 1ns / 1ps
`default_nettype none
interface mbad_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mbad_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

@@ rtl/mbad_out_if.sv @@
// Valid/ready channel carrying one scaled channel average.
`timescale 1ns / 1ps
`default_nettype none
interface mbad_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mbad_pkg::AVG_W-1:0]   average_out;
    logic [mbad_pkg::CHAN_IDX_W-1:0]     channel_index;
    logic                                 frame_last;

    modport source (output valid, output average_out, output channel_index,
                    output frame_last, input ready);
    modport sink   (input valid, input average_out, input channel_index,
                    input frame_last, output ready);
endinterface
`default_nettype wire

@@ rtl/mbad_cfg_regs.sv @@
// APB-style configuration registers of the decimator.
`timescale 1ns / 1ps
`default_nettype none
module mbad_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mbad_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [mbad_pkg::PDATA_W-1:0]       pwdata,
    output logic [mbad_pkg::PDATA_W-1:0]            prdata,
    output logic                                    pready,
    output mbad_pkg::t_cfg                          o_cfg
);

    logic [mbad_pkg::NCH_W-1:0]          r_num_channels;
    logic [mbad_pkg::FLEN_W-1:0]         r_frame_length;
    logic signed [mbad_pkg::SCALE_W-1:0] r_output_scale;
    logic [1:0]                          reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= mbad_pkg::NUM_CHANNELS_RST;
            r_frame_length <= mbad_pkg::FRAME_LENGTH_RST;
            r_output_scale <= mbad_pkg::OUTPUT_SCALE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                mbad_pkg::REG_NUM_CHANNELS: begin
                    r_num_channels <= pwdata[mbad_pkg::NCH_W-1:0];
                end
                mbad_pkg::REG_FRAME_LENGTH: begin
                    r_frame_length <= pwdata[mbad_pkg::FLEN_W-1:0];
                end
                mbad_pkg::REG_OUTPUT_SCALE: begin
                    r_output_scale <= signed'(pwdata[mbad_pkg::SCALE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            mbad_pkg::REG_NUM_CHANNELS: prdata = mbad_pkg::PDATA_W'(r_num_channels);
            mbad_pkg::REG_FRAME_LENGTH: prdata = mbad_pkg::PDATA_W'(r_frame_length);
            mbad_pkg::REG_OUTPUT_SCALE: prdata = mbad_pkg::PDATA_W'(unsigned'(r_output_scale));
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.num_channels = r_num_channels;
    assign o_cfg.frame_length = r_frame_length;
    assign o_cfg.output_scale = r_output_scale;

endmodule
`default_nettype wire

@@ rtl/mbad_accum.sv @@
// Channel/row sequencing and read-modify-write of the per-channel sum memory.
`timescale 1ns / 1ps
`default_nettype none
module mbad_accum #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_FRAME    = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mbad_pkg::t_cfg    i_cfg,
    mbad_in_if.sink                i_sample_chan,
    output logic                   o_sc_valid,
    output mbad_pkg::t_sc_req      o_sc_req,
    input  wire logic              i_sc_ready
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EW = $clog2(MAX_CHANNELS + 1);
    localparam int RW = $clog2(MAX_FRAME);
    localparam int FW = $clog2(MAX_FRAME + 1);
    localparam int SW = mbad_pkg::SUM_W;

    // Sequencing counters
    logic [CW-1:0] r_ch;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_ch;
    logic [RW-1:0] n_row;

    // Effective limits
    logic [EW-1:0] nc_eff;
    logic [FW-1:0] fl_eff;

    // Current item decode
    logic [CW-1:0] ch0;
    logic [RW-1:0] row0;
    logic          ch_wrap;
    logic          row_wrap;
    logic          in_fire;

    // Sum memory and read port
    logic [SW-1:0] r_sum_mem [MAX_CHANNELS];
    logic [SW-1:0] r_rd_data;

    // RMW stage
    logic                                 r_s1_v;
    logic [CW-1:0]                        r_s1_ch;
    logic signed [mbad_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                                 r_s1_load;
    logic                                 r_s1_emit;
    logic                                 r_s1_last;
    logic                                 r_s1_fwd;
    logic [SW-1:0]                        r_fwd_sum;
    logic [SW-1:0]                        s1_base;
    logic [SW-1:0]                        s1_sext;
    logic [SW-1:0]                        s1_sum;
    logic                                 s1_adv;

    // Finished-sum stage
    logic                                 r_s2_v;
    logic [SW-1:0]                        r_s2_sum;
    logic [CW-1:0]                        r_s2_ch;
    logic                                 r_s2_last;

    // Clamp register values to the supported range
    always_comb begin
        if (i_cfg.num_channels == '0) begin
            nc_eff = EW'(1);
        end else if (32'(i_cfg.num_channels) > MAX_CHANNELS) begin
            nc_eff = EW'(MAX_CHANNELS);
        end else begin
            nc_eff = EW'(i_cfg.num_channels);
        end
        if (i_cfg.frame_length == '0) begin
            fl_eff = FW'(1);
        end else if (32'(i_cfg.frame_length) > MAX_FRAME) begin
            fl_eff = FW'(MAX_FRAME);
        end else begin
            fl_eff = FW'(i_cfg.frame_length);
        end
    end

    // Position of the incoming sample and the counters after it
    always_comb begin
        ch0      = (EW'(r_ch) >= nc_eff) ? '0 : r_ch;
        row0     = (FW'(r_row) >= fl_eff) ? '0 : r_row;
        ch_wrap  = (EW'(ch0) + EW'(1)) >= nc_eff;
        row_wrap = (FW'(row0) + FW'(1)) >= fl_eff;
        n_ch     = ch_wrap ? '0 : ch0 + CW'(1);
        if (ch_wrap) begin
            n_row = row_wrap ? '0 : row0 + RW'(1);
        end else begin
            n_row = row0;
        end
    end

    // Handshakes
    assign s1_adv              = r_s1_v && (!r_s1_emit || !r_s2_v || i_sc_ready);
    assign i_sample_chan.ready = !r_s1_v || s1_adv;
    assign in_fire             = i_sample_chan.valid && i_sample_chan.ready;

    // Load or accumulate, with forwarding of a same-channel write
    assign s1_sext = {{(SW - mbad_pkg::SAMPLE_W){r_s1_sample[mbad_pkg::SAMPLE_W-1]}},
                      r_s1_sample};
    assign s1_base = r_s1_fwd ? r_fwd_sum : r_rd_data;
    assign s1_sum  = r_s1_load ? s1_sext : s1_base + s1_sext;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ch  <= n_ch;
                r_row <= n_row;
            end
            if (in_fire) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv && r_s1_emit) begin
                r_s2_v <= 1'b1;
            end else if (i_sc_ready) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    // RMW stage payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ch     <= ch0;
            r_s1_sample <= i_sample_chan.sample_in;
            r_s1_load   <= (row0 == '0);
            r_s1_emit   <= (FW'(row0) == fl_eff - FW'(1));
            r_s1_last   <= (FW'(row0) == fl_eff - FW'(1)) &&
                           (EW'(ch0) == nc_eff - EW'(1));
            r_s1_fwd    <= s1_adv && (r_s1_ch == ch0);
            r_fwd_sum   <= s1_sum;
        end
    end

    // Sum memory: write back from the RMW stage
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_sum_mem[r_s1_ch] <= s1_sum;
        end
    end

    // Sum memory: registered read for the accepted sample
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_data <= r_sum_mem[ch0];
        end
    end

    // Finished-sum stage payload
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_s2_sum  <= s1_sum;
            r_s2_ch   <= r_s1_ch;
            r_s2_last <= r_s1_last;
        end
    end

    assign o_sc_valid             = r_s2_v;
    assign o_sc_req.sum           = signed'(r_s2_sum);
    assign o_sc_req.channel_index = mbad_pkg::CHAN_IDX_W'(r_s2_ch);
    assign o_sc_req.frame_last    = r_s2_last;

    // An accepted sample always occupies the RMW stage next cycle
    a_fire_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_v)
        else $error("accepted sample did not enter the RMW stage");

    // A blocked RMW item keeps its channel so the write-back address holds
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_adv) |=> (r_s1_v && $stable(r_s1_ch)))
        else $error("blocked RMW item lost or changed channel");

    // The frame-last flag only rides on an emitting row
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_last) |-> r_s1_emit)
        else $error("frame_last set on a row that does not emit");

endmodule
`default_nettype wire

@@ rtl/mbad_scale.sv @@
// Scale multiply, floor shift by 16, saturation and the output register.
`timescale 1ns / 1ps
`default_nettype none
module mbad_scale (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic signed [mbad_pkg::SCALE_W-1:0]  i_scale,
    input  wire logic                                 i_req_valid,
    input  wire mbad_pkg::t_sc_req                    i_req,
    output logic                                      o_req_ready,
    mbad_out_if.source                                o_avg_chan
);

    localparam int PW = mbad_pkg::PROD_W;

    // Product stage
    logic                                  r_p_v;
    logic signed [PW-1:0]                  r_prod;
    logic [mbad_pkg::CHAN_IDX_W-1:0]       r_p_ch;
    logic                                  r_p_last;
    logic signed [PW-1:0]                  n_prod;
    logic                                  p_adv;

    // Output register
    logic                                  r_o_v;
    logic signed [mbad_pkg::AVG_W-1:0]     r_o_avg;
    logic [mbad_pkg::CHAN_IDX_W-1:0]       r_o_ch;
    logic                                  r_o_last;

    // Shift and saturate
    logic signed [PW-17:0]                 quo;
    logic signed [mbad_pkg::AVG_W-1:0]     n_avg;

    assign p_adv       = r_p_v && (!r_o_v || o_avg_chan.ready);
    assign o_req_ready = !r_p_v || p_adv;

    assign n_prod = i_req.sum * i_scale;

    // Arithmetic shift gives the floor of product / 2^16
    assign quo = signed'(r_prod[PW-1:16]);

    always_comb begin
        if (quo > mbad_pkg::SAT_HI) begin
            n_avg = mbad_pkg::AVG_MAX;
        end else if (quo < mbad_pkg::SAT_LO) begin
            n_avg = mbad_pkg::AVG_MIN;
        end else begin
            n_avg = signed'(quo[mbad_pkg::AVG_W-1:0]);
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                r_p_v <= 1'b1;
            end else if (p_adv) begin
                r_p_v <= 1'b0;
            end
            if (p_adv) begin
                r_o_v <= 1'b1;
            end else if (o_avg_chan.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // Product stage payload
    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_prod   <= n_prod;
            r_p_ch   <= i_req.channel_index;
            r_p_last <= i_req.frame_last;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_o_avg  <= n_avg;
            r_o_ch   <= r_p_ch;
            r_o_last <= r_p_last;
        end
    end

    assign o_avg_chan.valid         = r_o_v;
    assign o_avg_chan.average_out   = r_o_avg;
    assign o_avg_chan.channel_index = r_o_ch;
    assign o_avg_chan.frame_last    = r_o_last;

endmodule
`default_nettype wire

@@ rtl/multichannel_block_average_decimator.sv @@
// A last-row sum passes the RMW, finished-sum and product stages into the output register.
// Throughput: one sample per cycle unless stalled; the sum memory is read on acceptance
// and written back from the RMW stage; a register forwards back-to-back same-channel hits.
// A waiting result holds in the output register; three more can queue behind it, the third
// in the RMW stage, stalling all input; until then other rows' samples keep flowing.
// Reset (synchronous, active low): counters zero, registers to 1 / 2 / 0.5, pipeline empty;
// the sum memory is not cleared, each sum is loaded on the first row of a frame.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_block_average_decimator #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_FRAME    = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    mbad_in_if.sink                             i_sample_chan,
    mbad_out_if.source                          o_avg_chan,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mbad_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mbad_pkg::PDATA_W-1:0]   pwdata,
    output logic [mbad_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    mbad_pkg::t_cfg    cfg;
    mbad_pkg::t_sc_req sc_req;
    logic              sc_valid;
    logic              sc_ready;

    // Configuration registers
    mbad_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Per-channel accumulation
    mbad_accum #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_FRAME    (MAX_FRAME)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_sample_chan (i_sample_chan),
        .o_sc_valid    (sc_valid),
        .o_sc_req      (sc_req),
        .i_sc_ready    (sc_ready)
    );

    // Scaling and output
    mbad_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (cfg.output_scale),
        .i_req_valid (sc_valid),
        .i_req       (sc_req),
        .o_req_ready (sc_ready),
        .o_avg_chan  (o_avg_chan)
    );

endmodule
`default_nettype wire
